/* hdl/rcsq_pkg.sv */
// Package for the retrying command slot queue.
// Holds the sizes, status codes, state machine type and the structs shared by the memory, sequencer and top level.
// Depends on nothing.
`default_nettype none

package rcsq_pkg;

   // Table size and derived widths.
   localparam int SLOTS = 64;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int GAVE_W = 7;
   localparam logic [GAVE_W-1:0] GAVE_MAX = 7'd127;

   // Retry limit after reset.
   localparam logic [2:0] LIMIT_RESET = 3'd5;

   // Function codes of an input item.
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_SERVICE = 1'b1;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_SENT_OK   = 3'd1,
      ST_SEND_FAIL = 3'd2,
      ST_PUSHED    = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_PUSH,
      FSM_SCAN,
      FSM_DONE
   } fsm_type;

   // One accepted input item.
   typedef struct packed {
      logic       func;
      logic [7:0] cmd_byte;
      logic [7:0] value_byte;
      logic       write_ok;
   } item_type;

   // One slot of the command memory.
   typedef struct packed {
      logic [7:0] cmd;
      logic [7:0] value;
      logic [2:0] retries;
   } slot_type;

   // One result item.
   typedef struct packed {
      status_type        status;
      logic [7:0]        send_cmd;
      logic [7:0]        send_value;
      logic              bus_reset;
      logic [GAVE_W-1:0] given_up;
   } result_type;

   // Command memory port controls from the sequencer.
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      slot_type         wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

endpackage

`default_nettype wire

/* hdl/rcsq_if.sv */
// Channel interfaces of the retrying command slot queue: request, response and register write.
// Depends on nothing.
`default_nettype none

// Request channel: one item per handshake.
interface rcsq_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] cmd_byte;
   logic [7:0] value_byte;
   logic       write_ok;

   modport source (output valid, func, cmd_byte, value_byte, write_ok, input ready);
   modport sink (input valid, func, cmd_byte, value_byte, write_ok, output ready);
endinterface

// Response channel: one result item per handshake.
interface rcsq_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] send_cmd;
   logic [7:0] send_value;
   logic       bus_reset;
   logic [6:0] given_up;

   modport source (output valid, status, send_cmd, send_value, bus_reset, given_up,
                   input ready);
   modport sink (input valid, status, send_cmd, send_value, bus_reset, given_up,
                 output ready);
endinterface

// Register write channel carrying the retry limit.
interface rcsq_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

/* hdl/rcsq_mem.sv */
// Command memory: one slot per entry holding command, value and retry count.
// One write and one read port, read data registered. Depends on rcsq_pkg.
`default_nettype none

module rcsq_mem (
   input  logic                  clock,
   input  rcsq_pkg::mem_req_type mem_req,
   output rcsq_pkg::slot_type    rd_data
);

   rcsq_pkg::slot_type slot_mem_ff [rcsq_pkg::SLOTS];
   rcsq_pkg::slot_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         slot_mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Read port, read data registered.
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= slot_mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/rcsq_ctrl.sv */
// Sequencer of the slot queue: holds the pending flags and runs push and service scans
// over the command memory. Depends on rcsq_pkg.
`default_nettype none

module rcsq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_accept,
   input  rcsq_pkg::item_type    item,
   input  logic [2:0]            retry_limit,
   output logic                  item_ready,
   output logic                  res_valid,
   input  logic                  res_take,
   output rcsq_pkg::result_type  res,
   output rcsq_pkg::mem_req_type mem_req,
   input  rcsq_pkg::slot_type    rd_data
);

   rcsq_pkg::fsm_type                 state_ff, state_in;
   logic [rcsq_pkg::SLOTS-1:0]        pend_ff, pend_in;
   logic [rcsq_pkg::CNT_W-1:0]        idx_ff, idx_in;
   logic                              chk_vld_ff, chk_vld_in;
   logic [rcsq_pkg::IDX_W-1:0]        chk_idx_ff, chk_idx_in;
   rcsq_pkg::item_type                item_ff, item_in;
   logic [rcsq_pkg::GAVE_W-1:0]       gave_ff, gave_in;
   rcsq_pkg::result_type              res_ff, res_in;

   logic                              idx_end;
   logic [rcsq_pkg::IDX_W-1:0]        idx_lo;
   logic                              chk_pend;
   logic                              hit;
   logic                              drop;
   logic                              push_free;
   logic                              scan_empty;

   // Scan decisions for the slot being issued and the slot being checked.
   always_comb begin
      idx_end    = (idx_ff == rcsq_pkg::CNT_W'(rcsq_pkg::SLOTS));
      idx_lo     = idx_ff[rcsq_pkg::IDX_W-1:0];
      chk_pend   = pend_ff[chk_idx_ff];
      hit        = chk_vld_ff && chk_pend && (rd_data.retries < retry_limit);
      drop       = chk_vld_ff && chk_pend && !(rd_data.retries < retry_limit);
      push_free  = !idx_end && !pend_ff[idx_lo];
      scan_empty = !chk_vld_ff && idx_end;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rcsq_pkg::FSM_IDLE: begin
            if (item_accept) begin
               state_in = (item.func == rcsq_pkg::FUNC_SERVICE) ? rcsq_pkg::FSM_SCAN
                                                                 : rcsq_pkg::FSM_PUSH;
            end
         end
         rcsq_pkg::FSM_PUSH: begin
            if (idx_end || push_free) begin
               state_in = rcsq_pkg::FSM_DONE;
            end
         end
         rcsq_pkg::FSM_SCAN: begin
            if (hit || scan_empty) begin
               state_in = rcsq_pkg::FSM_DONE;
            end
         end
         rcsq_pkg::FSM_DONE: begin
            if (res_take) begin
               state_in = rcsq_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = rcsq_pkg::FSM_IDLE;
         end
      endcase
   end

   // Datapath updates and memory accesses for each state.
   always_comb begin
      pend_in    = pend_ff;
      idx_in     = idx_ff;
      chk_vld_in = chk_vld_ff;
      chk_idx_in = chk_idx_ff;
      item_in    = item_ff;
      gave_in    = gave_ff;
      res_in     = res_ff;
      mem_req    = '0;
      case (state_ff)
         rcsq_pkg::FSM_IDLE: begin
            if (item_accept) begin
               item_in    = item;
               idx_in     = '0;
               chk_vld_in = 1'b0;
               gave_in    = '0;
            end
         end
         rcsq_pkg::FSM_PUSH: begin
            // Look for the lowest free slot, one flag per cycle.
            res_in = '0;
            if (idx_end) begin
               res_in.status = rcsq_pkg::ST_FULL;
            end else if (push_free) begin
               mem_req.wr_en           = 1'b1;
               mem_req.wr_addr         = idx_lo;
               mem_req.wr_data.cmd     = item_ff.cmd_byte;
               mem_req.wr_data.value   = item_ff.value_byte;
               mem_req.wr_data.retries = 3'd0;
               pend_in[idx_lo]         = 1'b1;
               res_in.status           = rcsq_pkg::ST_PUSHED;
            end else begin
               idx_in = rcsq_pkg::CNT_W'(idx_ff + 1'b1);
            end
         end
         rcsq_pkg::FSM_SCAN: begin
            // Issue the read of the next slot while checking the previous one.
            mem_req.rd_en   = !idx_end;
            mem_req.rd_addr = idx_lo;
            chk_vld_in      = !idx_end;
            chk_idx_in      = idx_lo;
            if (!idx_end) begin
               idx_in = rcsq_pkg::CNT_W'(idx_ff + 1'b1);
            end
            if (hit) begin
               // First slot under the limit: count the attempt and send it.
               mem_req.wr_en           = 1'b1;
               mem_req.wr_addr         = chk_idx_ff;
               mem_req.wr_data.cmd     = rd_data.cmd;
               mem_req.wr_data.value   = rd_data.value;
               mem_req.wr_data.retries = 3'(rd_data.retries + 3'd1);
               if (item_ff.write_ok) begin
                  pend_in[chk_idx_ff] = 1'b0;
               end
               res_in.status     = item_ff.write_ok ? rcsq_pkg::ST_SENT_OK
                                                    : rcsq_pkg::ST_SEND_FAIL;
               res_in.send_cmd   = rd_data.cmd;
               res_in.send_value = rd_data.value;
               res_in.bus_reset  = !item_ff.write_ok;
               res_in.given_up   = gave_ff;
               chk_vld_in        = 1'b0;
            end else if (drop) begin
               // Retries exhausted: release the slot and count it.
               pend_in[chk_idx_ff] = 1'b0;
               if (gave_ff != rcsq_pkg::GAVE_MAX) begin
                  gave_in = rcsq_pkg::GAVE_W'(gave_ff + 1'b1);
               end
            end
            if (scan_empty) begin
               res_in          = '0;
               res_in.status   = rcsq_pkg::ST_IDLE;
               res_in.given_up = gave_ff;
            end
         end
         rcsq_pkg::FSM_DONE: begin
            res_in = res_ff;
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rcsq_pkg::FSM_IDLE;
         pend_ff    <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pend_ff    <= pend_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      chk_idx_ff <= chk_idx_in;
      item_ff    <= item_in;
      gave_ff    <= gave_in;
      res_ff     <= res_in;
   end

   assign item_ready = (state_ff == rcsq_pkg::FSM_IDLE);
   assign res_valid  = (state_ff == rcsq_pkg::FSM_DONE);
   assign res        = res_ff;

endmodule

`default_nettype wire

/* hdl/retrying_command_slot_queue.sv */
// Top level of the retrying command slot queue: channels, retry limit register,
// response register. Depends on rcsq_pkg, rcsq_if, rcsq_mem and rcsq_ctrl.
//
//   Channel   Direction  Carries
//   req_ch    in         func, cmd_byte, value_byte, write_ok
//   rsp_ch    out        status, send_cmd, send_value, bus_reset, given_up
//   csr_ch    in         retry_limit write data
//
// One item at a time. A push walks the pending flags one slot a cycle from index 0 and
// writes the lowest free slot, or reports ST_FULL when every flag is set.
// A service scan reads the command memory one slot a cycle through the registered read
// port and sends the first pending slot under the retry limit, or reports ST_IDLE.
// Reset clears the pending flags at once; there is no clearing pass.
// A result waits in the response register; the next item is taken while it waits.
`default_nettype none

module retrying_command_slot_queue (
   input  logic        clock,
   input  logic        reset,
   rcsq_req_if.sink    req_ch,
   rcsq_rsp_if.source  rsp_ch,
   rcsq_csr_if.sink    csr_ch
);

   logic [2:0]            limit_ff, limit_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   rcsq_pkg::result_type  rsp_data_ff, rsp_data_in;

   logic                  item_accept;
   rcsq_pkg::item_type    item;
   logic                  item_ready;
   logic                  res_valid;
   logic                  res_take;
   rcsq_pkg::result_type  res;
   rcsq_pkg::mem_req_type mem_req;
   rcsq_pkg::slot_type    rd_data;

   // Request side.
   assign req_ch.ready    = item_ready;
   assign item_accept     = req_ch.valid && item_ready;
   assign item.func       = req_ch.func;
   assign item.cmd_byte   = req_ch.cmd_byte;
   assign item.value_byte = req_ch.value_byte;
   assign item.write_ok   = req_ch.write_ok;

   // Retry limit register.
   assign csr_ch.ready = 1'b1;
   always_comb begin
      limit_in = limit_ff;
      if (csr_ch.valid) begin
         limit_in = csr_ch.data;
      end
   end

   // Response register loads when empty or being emptied.
   assign res_take = res_valid && (!rsp_vld_ff || rsp_ch.ready);
   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (res_take) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = res;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= rcsq_pkg::LIMIT_RESET;
         rsp_vld_ff <= 1'b0;
      end else begin
         limit_ff   <= limit_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.status     = rsp_data_ff.status;
   assign rsp_ch.send_cmd   = rsp_data_ff.send_cmd;
   assign rsp_ch.send_value = rsp_data_ff.send_value;
   assign rsp_ch.bus_reset  = rsp_data_ff.bus_reset;
   assign rsp_ch.given_up   = rsp_data_ff.given_up;

   // Sequencer and command memory.
   rcsq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .item        (item),
      .retry_limit (limit_ff),
      .item_ready  (item_ready),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .res         (res),
      .mem_req     (mem_req),
      .rd_data     (rd_data)
   );

   rcsq_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // A bus reset is shown exactly with a failed send.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.bus_reset == (rsp_ch.status == rcsq_pkg::ST_SEND_FAIL)))
      else $error("bus_reset does not match a failed send");

   // A push result never reports released slots or bus data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status == rcsq_pkg::ST_PUSHED ||
                        rsp_ch.status == rcsq_pkg::ST_FULL))
      |-> (rsp_ch.given_up == '0 && rsp_ch.send_cmd == '0 && rsp_ch.send_value == '0))
      else $error("push result carries scan fields");

   // Only one item is in work: the request side closes after an accept.
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("second item taken while one is in work");

   // A register write lands in the retry limit.
   assert property (@(posedge clock) disable iff (reset)
      (csr_ch.valid && csr_ch.ready) |=> (limit_ff == $past(csr_ch.data)))
      else $error("retry limit write lost");

endmodule

`default_nettype wire
